/* rtl/powerline_job_queue_with_ack_retry_macros.svh */
// assertion macros for the powerline job queue
`ifndef POWERLINE_JOB_QUEUE_WITH_ACK_RETRY_MACROS_SVH
`define POWERLINE_JOB_QUEUE_WITH_ACK_RETRY_MACROS_SVH

`ifndef SYNTHESIS
`define PJQ_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pjq assertion failed");
`define PJQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pjq assertion failed");
`else
`define PJQ_ASSERT(label, clk, rst_n, ante, cons)
`define PJQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/pjq_pkg.sv */
`timescale 1ns / 1ps
package pjq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RETRY   = 3;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int SEND_W      = 3;
    localparam int OUT_CNT_W   = 5;
    localparam int RX_BYTES    = 9;
    localparam int RX_BUF      = 16;

    localparam logic       OP_ENQUEUE = 1'b0;
    localparam logic       OP_POLL    = 1'b1;

    localparam logic [3:0] RX_TIMEOUT = 4'd0;
    localparam logic [3:0] RX_FULL    = 4'd9;

    localparam logic [1:0] KIND_ON  = 2'd0;
    localparam logic [1:0] KIND_OFF = 2'd1;
    localparam logic [1:0] KIND_DIM = 2'd2;
    localparam logic [1:0] KIND_IDS = 2'd3;

    localparam logic [7:0] STX_BYTE      = 8'h02;
    localparam logic [7:0] ETX_BYTE      = 8'h03;
    localparam logic [7:0] TX_LEN_BYTE   = 8'h05;
    localparam logic [7:0] RX_LEN_BYTE   = 8'h06;
    localparam logic [7:0] CMD_ON        = 8'h22;
    localparam logic [7:0] CMD_OFF       = 8'h23;
    localparam logic [7:0] CMD_DIM       = 8'h2c;
    localparam logic [7:0] CMD_IDS       = 8'h1c;
    localparam logic [7:0] REPEAT_BIT    = 8'h40;
    localparam logic [7:0] DIM_DATA2     = 8'h03;
    localparam logic [7:0] CTL_ACK       = 8'h20;
    localparam logic [7:0] CTL_ID        = 8'h40;
    localparam logic [7:0] CTL_COPY_MASK = 8'h1c;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PARSE,
        S_SEND
    } t_state;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  job_house_unit;
        logic [7:0]  job_usercode;
        logic [1:0]  job_kind;
        logic [7:0]  job_level;
        logic [3:0]  rx_count;
        logic [63:0] rx_head_bytes;
        logic [7:0]  rx_tail_byte;
    } t_in_item;

    typedef struct packed {
        logic        tx_valid;
        logic [63:0] tx_frame;
        logic        id_valid;
        logic [3:0]  id_house;
        logic [15:0] id_units;
        logic        ack_removed;
        logic        job_dropped;
        logic        enqueue_rejected;
        logic [4:0]  queue_count;
    } t_out_item;

    typedef struct packed {
        logic [7:0] hu;
        logic [7:0] uc;
        logic [1:0] kind;
        logic [7:0] level;
    } t_job;

    typedef struct packed {
        logic capture;
        logic parse;
        logic send;
    } t_dp_cmd;

    function automatic logic [QIDX_W-1:0] idx_inc(input logic [QIDX_W-1:0] idx);
        logic [QIDX_W-1:0] res;
        if (idx == QIDX_W'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + QIDX_W'(1);
        end
        return res;
    endfunction

    function automatic logic [7:0] cmd_byte(input logic [1:0] kind, input logic three_phase);
        logic [7:0] rep;
        logic [7:0] res;
        rep = three_phase ? REPEAT_BIT : 8'h00;
        case (kind)
            KIND_ON:  res = CMD_ON | rep;
            KIND_OFF: res = CMD_OFF | rep;
            KIND_DIM: res = CMD_DIM | rep;
            default:  res = CMD_IDS;
        endcase
        return res;
    endfunction

endpackage

/* rtl/pjq_ctrl.sv */
`timescale 1ns / 1ps
module pjq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output pjq_pkg::t_dp_cmd o_cmd
);
    import pjq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_PARSE;
                end
            end
            S_PARSE: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_PARSE: begin
                o_cmd.parse = 1'b1;
            end
            S_SEND: begin
                o_cmd.send = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        if (o_cmd.send) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/pjq_datapath.sv */
`timescale 1ns / 1ps
module pjq_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pjq_pkg::t_dp_cmd   i_cmd,
    input  pjq_pkg::t_in_item  i_in_item,
    input  logic               i_cfg_we,
    input  logic               i_cfg_data,
    output pjq_pkg::t_out_item o_out_item
);
    import pjq_pkg::*;

    t_in_item          r_item;
    t_job              r_store [QUEUE_DEPTH];
    t_job              r_head_job;
    logic [QIDX_W-1:0] r_head;
    logic [QIDX_W-1:0] r_tail;
    logic [QCNT_W-1:0] r_count;
    logic [SEND_W-1:0] r_sends;
    logic              r_three_phase;
    logic              r_ack;
    logic              r_idv;
    logic [3:0]        r_id_house;
    logic [15:0]       r_id_units;
    logic              r_send_ok;
    logic              r_rej;
    t_out_item         r_out;

    logic [QIDX_W-1:0] n_head;
    logic [QIDX_W-1:0] n_tail;
    logic [QCNT_W-1:0] n_count;
    logic [SEND_W-1:0] n_sends;

    logic [7:0] rx_b [RX_BUF];
    logic       found;
    logic [3:0] fidx;
    logic       frame_ok;
    logic [7:0] fr_hu;
    logic [7:0] fr_d1;
    logic [7:0] fr_d2;
    logic [7:0] fr_ctl;
    logic       is_poll;
    logic       full;
    logic       nonempty;
    logic       ack_hit;
    logic       id_fb;
    logic       bus_copy;
    logic       cnt_ok;
    logic       store_we;
    logic       send;
    logic       drop;
    t_job       head_job;
    t_job       new_job;
    logic [7:0] tx_cmd;
    logic [7:0] tx_d2;
    t_out_item  n_out;

    always_comb begin
        for (int k = 0; k < RX_BUF; k++) begin
            rx_b[k] = 8'h00;
        end
        for (int k = 0; k < 8; k++) begin
            rx_b[k] = r_item.rx_head_bytes[8*k +: 8];
        end
        rx_b[8] = r_item.rx_tail_byte;
    end

    // first start byte among the received bytes
    always_comb begin
        found = 1'b0;
        fidx  = '0;
        for (int k = 0; k < RX_BYTES; k++) begin
            if (!found && rx_b[k] == STX_BYTE) begin
                found = 1'b1;
                fidx  = 4'(k);
            end
        end
    end

    assign is_poll  = (r_item.cmd == OP_POLL);
    assign full     = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign nonempty = (r_count != '0);
    assign head_job = r_head_job;
    assign new_job  = '{hu: r_item.job_house_unit, uc: r_item.job_usercode,
                        kind: r_item.job_kind, level: r_item.job_level};

    assign frame_ok = (r_item.rx_count == RX_FULL) && found
                      && (rx_b[fidx + 4'd1] == RX_LEN_BYTE);
    assign fr_hu    = rx_b[fidx + 4'd3];
    assign fr_d1    = rx_b[fidx + 4'd5];
    assign fr_d2    = rx_b[fidx + 4'd6];
    assign fr_ctl   = rx_b[fidx + 4'd7];

    assign ack_hit  = frame_ok && ((fr_ctl & CTL_ACK) != '0) && nonempty
                      && (head_job.hu == fr_hu);
    assign id_fb    = frame_ok && ((fr_ctl & CTL_ACK) == '0) && ((fr_ctl & CTL_ID) != '0);
    assign bus_copy = frame_ok && ((fr_ctl & CTL_ACK) == '0) && ((fr_ctl & CTL_ID) == '0)
                      && ((fr_ctl & CTL_COPY_MASK) != '0);
    assign cnt_ok   = (r_item.rx_count == RX_TIMEOUT) || (r_item.rx_count == RX_FULL);

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_sends  = r_sends;
        store_we = 1'b0;
        send     = 1'b0;
        drop     = 1'b0;
        if (i_cmd.parse) begin
            if (!is_poll) begin
                if (!full) begin
                    store_we = 1'b1;
                    n_tail   = idx_inc(r_tail);
                    n_count  = r_count + QCNT_W'(1);
                end
            end else if (ack_hit || (id_fb && nonempty)) begin
                n_head  = idx_inc(r_head);
                n_count = r_count - QCNT_W'(1);
                n_sends = '0;
            end
        end
        if (i_cmd.send) begin
            send = is_poll && r_send_ok && nonempty;
            if (send) begin
                if (r_sends == SEND_W'(MAX_RETRY)) begin
                    drop    = 1'b1;
                    n_head  = idx_inc(r_head);
                    n_count = r_count - QCNT_W'(1);
                    n_sends = '0;
                end else begin
                    n_sends = r_sends + SEND_W'(1);
                end
            end
        end
    end

    assign tx_cmd = cmd_byte(head_job.kind, r_three_phase);
    assign tx_d2  = (head_job.kind == KIND_DIM) ? DIM_DATA2 : 8'h00;

    always_comb begin
        n_out                  = '0;
        n_out.tx_valid         = send;
        if (send) begin
            n_out.tx_frame = {ETX_BYTE, tx_d2, head_job.level, tx_cmd,
                              head_job.hu, head_job.uc, TX_LEN_BYTE, STX_BYTE};
        end
        n_out.id_valid         = r_idv;
        n_out.id_house         = r_id_house;
        n_out.id_units         = r_id_units;
        n_out.ack_removed      = r_ack;
        n_out.job_dropped      = drop;
        n_out.enqueue_rejected = r_rej;
        n_out.queue_count      = OUT_CNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
            r_sends       <= '0;
            r_three_phase <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_sends <= n_sends;
            if (i_cfg_we) begin
                r_three_phase <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end
        if (store_we) begin
            r_store[r_tail] <= new_job;
        end
        // head entry as it stands after this edge
        if (store_we && (r_tail == n_head)) begin
            r_head_job <= new_job;
        end else begin
            r_head_job <= r_store[n_head];
        end
        if (i_cmd.parse) begin
            r_ack      <= is_poll && ack_hit;
            r_idv      <= is_poll && id_fb;
            r_id_house <= (is_poll && id_fb) ? fr_hu[7:4] : 4'h0;
            r_id_units <= (is_poll && id_fb) ? {fr_d1, fr_d2} : 16'h0000;
            r_send_ok  <= cnt_ok && !bus_copy;
            r_rej      <= !is_poll && full;
        end
        if (i_cmd.send) begin
            r_out <= n_out;
        end
    end

    assign o_out_item = r_out;

endmodule

/* rtl/powerline_job_queue_with_ack_retry.sv */
`timescale 1ns / 1ps
// sequence: an accepted item is parsed, then sent; its result is registered in the send step
// a new item is taken only once the last one is through the three-step controller sequence;
// the send step waits while the output holds a result that has not been taken
// reset: synchronous, active low; clears queue pointers, job count, send count,
// three_phase and the controller; the job store holds whatever it had
`include "powerline_job_queue_with_ack_retry_macros.svh"
module powerline_job_queue_with_ack_retry (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pjq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pjq_pkg::t_out_item o_out_item
);
    import pjq_pkg::*;

    t_dp_cmd dp_cmd;
    logic    cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    pjq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (dp_cmd)
    );

    pjq_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_in_item  (i_in_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_out_item (o_out_item)
    );

    `PJQ_ASSERT(a_count_bound, i_clk, i_rst_n, o_out_valid, o_out_item.queue_count <= OUT_CNT_W'(QUEUE_DEPTH))
    `PJQ_ASSERT(a_reject_alone, i_clk, i_rst_n, o_out_valid && o_out_item.enqueue_rejected, !o_out_item.tx_valid && !o_out_item.id_valid)
    `PJQ_ASSERT(a_idle_frame, i_clk, i_rst_n, o_out_valid && !o_out_item.tx_valid, o_out_item.tx_frame == '0)
    `PJQ_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule

/* test/powerline_job_queue_with_ack_retry_tb.sv */
`timescale 1ns / 1ps
module powerline_job_queue_with_ack_retry_tb;
    import pjq_pkg::*;

    typedef struct packed {
        t_job       job;
        logic [2:0] sends;
    } t_slot;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic      i_cfg_data = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    // shadow of the job queue
    t_slot slots[QUEUE_DEPTH];
    int    head_ptr = 0;
    int    tail_ptr = 0;
    int    jobs_held = 0;
    logic  repeat_mode = 1'b0;

    t_in_item  job_items[$];
    t_out_item expected_results[$];
    t_out_item head_want;
    logic      item_taken = 1'b0;
    logic [7:0] addr_pool[4];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic long_hold_req = 1'b0;
    int hold_left = 0;

    int mismatches = 0;
    int items_in = 0;
    int results_seen = 0;
    int frames_sent = 0;
    int acks_taken = 0;
    int id_reports = 0;
    int jobs_dropped = 0;
    int enq_refused = 0;

    powerline_job_queue_with_ack_retry DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void drop_head();
        if (jobs_held > 0) begin
            head_ptr = (head_ptr + 1) % QUEUE_DEPTH;
            jobs_held--;
        end
    endfunction

    function automatic t_out_item queue_step(input t_in_item it);
        t_out_item  res;
        logic [7:0] rx[16];
        logic [7:0] ctl;
        logic [7:0] hu;
        logic [7:0] cmdb;
        logic [7:0] d2;
        logic       send;
        int         pos;
        int         k;
        res = '0;
        if (it.cmd == OP_ENQUEUE) begin
            if (jobs_held >= QUEUE_DEPTH) begin
                res.enqueue_rejected = 1'b1;
            end else begin
                slots[tail_ptr].job.hu = it.job_house_unit;
                slots[tail_ptr].job.uc = it.job_usercode;
                slots[tail_ptr].job.kind = it.job_kind;
                slots[tail_ptr].job.level = it.job_level;
                slots[tail_ptr].sends = 3'd0;
                tail_ptr = (tail_ptr + 1) % QUEUE_DEPTH;
                jobs_held++;
            end
        end else begin
            send = (it.rx_count == RX_TIMEOUT) || (it.rx_count == RX_FULL);
            if (it.rx_count == RX_FULL) begin
                for (k = 0; k < 16; k++) rx[k] = 8'h00;
                for (k = 0; k < 8; k++) rx[k] = it.rx_head_bytes[8*k +: 8];
                rx[8] = it.rx_tail_byte;
                pos = 0;
                while (pos < 9 && rx[pos] != STX_BYTE) pos++;
                if (pos < 9 && rx[pos + 1] == RX_LEN_BYTE) begin
                    hu = rx[pos + 3];
                    ctl = rx[pos + 7];
                    if ((ctl & CTL_ACK) != 8'h00) begin
                        if (jobs_held > 0 && slots[head_ptr].job.hu == hu) begin
                            drop_head();
                            res.ack_removed = 1'b1;
                        end
                    end else if ((ctl & CTL_ID) != 8'h00) begin
                        res.id_valid = 1'b1;
                        res.id_house = hu[7:4];
                        res.id_units = {rx[pos + 5], rx[pos + 6]};
                        drop_head();
                    end else if ((ctl & CTL_COPY_MASK) != 8'h00) begin
                        send = 1'b0;
                    end
                end
            end
            if (send && jobs_held > 0) begin
                d2 = 8'h00;
                case (slots[head_ptr].job.kind)
                    KIND_ON: cmdb = CMD_ON;
                    KIND_OFF: cmdb = CMD_OFF;
                    KIND_DIM: begin
                        cmdb = CMD_DIM;
                        d2 = DIM_DATA2;
                    end
                    default: cmdb = CMD_IDS;
                endcase
                if (repeat_mode && slots[head_ptr].job.kind != KIND_IDS) begin
                    cmdb = cmdb | REPEAT_BIT;
                end
                res.tx_valid = 1'b1;
                res.tx_frame = {ETX_BYTE, d2, slots[head_ptr].job.level, cmdb,
                                slots[head_ptr].job.hu, slots[head_ptr].job.uc,
                                TX_LEN_BYTE, STX_BYTE};
                slots[head_ptr].sends = slots[head_ptr].sends + 3'd1;
                if (slots[head_ptr].sends > MAX_RETRY) begin
                    drop_head();
                    res.job_dropped = 1'b1;
                end
            end
        end
        res.queue_count = OUT_CNT_W'(jobs_held);
        return res;
    endfunction

    function automatic t_in_item blank_item();
        t_in_item it;
        it.cmd = 1'($urandom);
        it.job_house_unit = 8'($urandom);
        it.job_usercode = 8'($urandom);
        it.job_kind = 2'($urandom);
        it.job_level = 8'($urandom);
        it.rx_count = 4'($urandom);
        it.rx_head_bytes = {$urandom, $urandom};
        it.rx_tail_byte = 8'($urandom);
        return it;
    endfunction

    function automatic t_in_item enqueue_item(input logic [7:0] hu, input logic [7:0] uc,
                                              input logic [1:0] kind, input logic [7:0] level);
        t_in_item it;
        it = blank_item();
        it.cmd = OP_ENQUEUE;
        it.job_house_unit = hu;
        it.job_usercode = uc;
        it.job_kind = kind;
        it.job_level = level;
        return it;
    endfunction

    function automatic t_in_item poll_item(input logic [3:0] cnt, input logic [71:0] rx);
        t_in_item it;
        it = blank_item();
        it.cmd = OP_POLL;
        it.rx_count = cnt;
        it.rx_head_bytes = rx[63:0];
        it.rx_tail_byte = rx[71:64];
        return it;
    endfunction

    function automatic logic [71:0] any_rx();
        return {8'($urandom), $urandom, $urandom};
    endfunction

    // stx at byte position at, nothing before it looks like stx
    function automatic logic [71:0] frame_rx(input int at, input logic [7:0] hu,
                                             input logic [7:0] d1, input logic [7:0] d2,
                                             input logic [7:0] ctl);
        logic [7:0]  fb[9];
        logic [7:0]  body[7];
        logic [71:0] res;
        int          k;
        body[0] = RX_LEN_BYTE;
        body[1] = 8'($urandom);
        body[2] = hu;
        body[3] = 8'($urandom);
        body[4] = d1;
        body[5] = d2;
        body[6] = ctl;
        for (k = 0; k < 9; k++) begin
            fb[k] = 8'($urandom);
            if (fb[k] == STX_BYTE) fb[k] = ETX_BYTE;
        end
        fb[at] = STX_BYTE;
        for (k = 0; k < 7; k++) begin
            if (at + 1 + k < 9) fb[at + 1 + k] = body[k];
        end
        for (k = 0; k < 9; k++) res[8*k +: 8] = fb[k];
        return res;
    endfunction

    function automatic logic [71:0] noise_rx();
        logic [71:0] res;
        res = any_rx();
        if ($urandom_range(1) == 0) begin
            res[7:0] = STX_BYTE;
            if (res[15:8] == RX_LEN_BYTE) res[15:8] = ETX_BYTE;
        end
        return res;
    endfunction

    function automatic logic [7:0] pick_addr();
        return ($urandom_range(99) < 70) ? addr_pool[$urandom_range(3)] : 8'($urandom);
    endfunction

    function automatic t_in_item random_item(input int enq_pct);
        int         roll;
        int         at;
        logic [3:0] cnt;
        logic [7:0] ctl;
        roll = $urandom_range(99);
        if (roll < enq_pct) begin
            return enqueue_item(pick_addr(), 8'($urandom), 2'($urandom), 8'($urandom));
        end
        roll = $urandom_range(99);
        if (roll < 20) return poll_item(RX_TIMEOUT, any_rx());
        if (roll < 30) begin
            cnt = 4'($urandom_range(1, 14));
            if (cnt >= RX_FULL) cnt++;
            return poll_item(cnt, any_rx());
        end
        if (roll < 40) return poll_item(RX_FULL, noise_rx());
        roll = $urandom_range(99);
        ctl = 8'($urandom);
        if (roll < 35) begin
            ctl = ctl | CTL_ACK;
        end else if (roll < 50) begin
            ctl = (ctl & ~CTL_ACK) | CTL_ID;
        end else if (roll < 65) begin
            ctl = ctl & ~(CTL_ACK | CTL_ID);
            if ((ctl & CTL_COPY_MASK) == 8'h00) ctl = ctl | (8'h04 << $urandom_range(2));
        end else begin
            ctl = ctl & ~(CTL_ACK | CTL_ID | CTL_COPY_MASK);
        end
        at = ($urandom_range(9) != 0) ? $urandom_range(1) : $urandom_range(2, 8);
        return poll_item(RX_FULL, frame_rx(at, pick_addr(), 8'($urandom), 8'($urandom), ctl));
    endfunction

    task automatic queue_item(input t_in_item it);
        job_items = {job_items, it};
    endtask

    task automatic push_random(input int n, input int enq_pct);
        repeat (n) queue_item(random_item(enq_pct));
    endtask

    task automatic write_three_phase(input logic v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        repeat_mode = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        while (job_items.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (5) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: %s expected %h got %h", $realtime, name, want, got);
            end
        end
    endtask

    // item driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || item_taken) begin
            if (job_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_item <= job_items[0];
                job_items.delete(0);
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        item_taken = 1'b0;
    end

    // result receiver
    always @(negedge i_clk) begin
        if (long_hold_req) begin
            hold_left = 400;
            long_hold_req = 1'b0;
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_results = {expected_results, queue_step(i_in_item)};
                items_in++;
                item_taken = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result with nothing pending: %h", $realtime, o_out_item);
                    end
                end else begin
                    head_want = expected_results[0];
                    expected_results.delete(0);
                    results_seen++;
                    frames_sent += int'(head_want.tx_valid);
                    acks_taken += int'(head_want.ack_removed);
                    id_reports += int'(head_want.id_valid);
                    jobs_dropped += int'(head_want.job_dropped);
                    enq_refused += int'(head_want.enqueue_rejected);
                    check_field("tx_valid", 64'(head_want.tx_valid), 64'(o_out_item.tx_valid));
                    check_field("tx_frame", head_want.tx_frame, o_out_item.tx_frame);
                    check_field("id_valid", 64'(head_want.id_valid), 64'(o_out_item.id_valid));
                    check_field("id_house", 64'(head_want.id_house), 64'(o_out_item.id_house));
                    check_field("id_units", 64'(head_want.id_units), 64'(o_out_item.id_units));
                    check_field("ack_removed", 64'(head_want.ack_removed),
                                64'(o_out_item.ack_removed));
                    check_field("job_dropped", 64'(head_want.job_dropped),
                                64'(o_out_item.job_dropped));
                    check_field("enqueue_rejected", 64'(head_want.enqueue_rejected),
                                64'(o_out_item.enqueue_rejected));
                    check_field("queue_count", 64'(head_want.queue_count),
                                64'(o_out_item.queue_count));
                end
            end
        end
    end

    initial begin
        int k;
        for (k = 0; k < 4; k++) addr_pool[k] = 8'($urandom);
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed pass with three_phase at its reset value
        queue_item(poll_item(RX_TIMEOUT, any_rx()));
        queue_item(poll_item(RX_FULL, frame_rx(0, 8'h3c, 8'hff, 8'h00, CTL_ID)));
        queue_item(enqueue_item(8'h00, 8'h00, KIND_ON, 8'h00));
        queue_item(enqueue_item(8'hff, 8'hff, KIND_OFF, 8'hff));
        queue_item(enqueue_item(8'h5a, 8'h12, KIND_DIM, 8'h80));
        queue_item(enqueue_item(8'ha5, 8'h34, KIND_IDS, 8'h7f));
        queue_item(poll_item(RX_TIMEOUT, any_rx()));
        queue_item(poll_item(4'd8, any_rx()));
        queue_item(poll_item(4'd15, any_rx()));
        queue_item(poll_item(RX_FULL, frame_rx(0, 8'h00, 8'h00, 8'h00, CTL_COPY_MASK)));
        queue_item(poll_item(RX_FULL, frame_rx(0, 8'h11, 8'h00, 8'h00, CTL_ACK)));
        queue_item(poll_item(RX_FULL, frame_rx(1, 8'h00, 8'h00, 8'h00, 8'hff)));
        queue_item(poll_item(RX_FULL, frame_rx(1, 8'hc3, 8'h81, 8'h18, CTL_ID)));
        repeat (4) queue_item(poll_item(RX_TIMEOUT, any_rx()));
        queue_item(poll_item(RX_FULL, noise_rx()));
        queue_item(poll_item(RX_FULL, frame_rx(8, 8'h00, 8'h00, 8'h00, 8'h00)));
        queue_item(poll_item(RX_TIMEOUT, any_rx()));
        queue_item(poll_item(RX_TIMEOUT, any_rx()));
        queue_item(poll_item(4'd10, any_rx()));
        queue_item(poll_item(4'd1, any_rx()));
        wait_idle();

        write_three_phase(1'b1);
        push_random(400, 40);
        wait_idle();

        write_three_phase(1'b0);
        send_idle_pct = 78;
        push_random(400, 40);
        wait_idle();

        // enqueue heavy with a long output stall so the queue and the pipe fill
        write_three_phase(1'b1);
        send_idle_pct = 0;
        recv_stall_pct = 78;
        push_random(400, 75);
        @(posedge i_clk);
        long_hold_req = 1'b1;
        wait_idle();

        write_three_phase(1'b0);
        send_idle_pct = 28;
        recv_stall_pct = 28;
        push_random(400, 35);
        wait_idle();

        write_three_phase(1'b1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        push_random(400, 30);
        wait_idle();
        repeat (10) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            mismatches += expected_results.size();
            $display("%0d results never arrived", expected_results.size());
        end
        $display("%0d items in, %0d results checked; %0d frames sent, %0d acks, %0d id reports",
                 items_in, results_seen, frames_sent, acks_taken, id_reports);
        $display("%0d jobs dropped after retries, %0d enqueues refused, %0d mismatches",
                 jobs_dropped, enq_refused, mismatches);
        if (mismatches == 0) begin
            $display("powerline_job_queue_with_ack_retry_tb: PASS");
        end else begin
            $display("powerline_job_queue_with_ack_retry_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout");
        $display("powerline_job_queue_with_ack_retry_tb: FAIL");
        $finish;
    end

endmodule
